// File: hdl/swrl_pkg.sv
// Shared types and constants for the sliding-window rate limiter.
// No dependencies; imported by every module of the block.
package swrl_pkg;

   localparam int TABLE_ENTRIES = 1024;
   localparam int MAX_ATTEMPTS  = 32;
   localparam int KEY_BITS      = 32;

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int HEAD_W  = (MAX_ATTEMPTS > 1) ? $clog2(MAX_ATTEMPTS) : 1;
   localparam int CNT_W   = $clog2(MAX_ATTEMPTS + 1);
   localparam int ST_W    = $clog2(TABLE_ENTRIES * MAX_ATTEMPTS);
   localparam int TIME_W  = 48;
   localparam int WIN_W   = 32;
   localparam int LIMIT_W = 6;
   localparam int ATT_W   = 6;

   localparam logic [TIME_W-1:0] IDLE_TIMEOUT_RESET = 48'd3600000;

   typedef struct packed {
      logic [31:0]        client_key;
      logic [TIME_W-1:0]  now_ticks;
      logic [LIMIT_W-1:0] attempt_limit;
      logic [WIN_W-1:0]   window_ticks;
   } req_type;

   typedef struct packed {
      logic             allowed;
      logic [ATT_W-1:0] attempts_in_window;
      logic             new_entry;
      logic             untracked;
   } rsp_type;

   typedef struct packed {
      logic load_req;
      logic clr_ptr;
      logic inc_ptr;
      logic meta_rd;
      logic meta_clr;
      logic scan_eval;
      logic rec_eval;
      logic alloc;
      logic stamp_rd;
      logic pop;
      logic decide;
      logic untrack;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic last_ptr;
      logic hit;
      logic cand_found;
      logic cnt_zero;
      logic win_ok;
      logic expire;
   } sts_type;

endpackage

// File: hdl/swrl_datapath.sv
// Datapath: entry table, stamp memory, scan pointer, work registers, result.
// Depends on swrl_pkg; driven by swrl_ctrl commands.
module swrl_datapath (
   input  logic              clock,
   input  logic              reset,
   input  swrl_pkg::req_type req_data,
   input  logic              csr_we,
   input  logic [47:0]       csr_wdata,
   input  swrl_pkg::cmd_type cmd,
   output swrl_pkg::sts_type sts,
   output swrl_pkg::rsp_type rsp_data
);
   import swrl_pkg::*;

   typedef struct packed {
      logic                valid;
      logic [KEY_BITS-1:0] key;
      logic [TIME_W-1:0]   last_seen;
      logic [HEAD_W-1:0]   head;
      logic [CNT_W-1:0]    count;
   } meta_type;

   meta_type          meta_mem [TABLE_ENTRIES];
   logic [TIME_W-1:0] stamp_mem [TABLE_ENTRIES * MAX_ATTEMPTS];

   req_type           req_ff, req_in;
   logic [TIME_W-1:0] cutoff_ff, cutoff_in;
   logic              win_ok_ff, win_ok_in;
   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic [TIME_W-1:0] timeout_ff, timeout_in;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   meta_type          meta_q_ff;
   logic [TIME_W-1:0] stamp_q_ff;
   logic              cand_found_ff, cand_found_in;
   logic [IDX_W-1:0]  cand_slot_ff, cand_slot_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic [HEAD_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              fresh_ff, fresh_in;
   rsp_type           res_ff, res_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [KEY_BITS-1:0] key_w;
   logic                hit, idle_ok, this_idle, allowed;
   logic [CNT_W-1:0]    cnt_next;
   logic [HEAD_W:0]     pos_sum;
   logic [HEAD_W-1:0]   push_pos;
   logic [ST_W-1:0]     st_base, st_rd_addr, st_wr_addr;
   logic                meta_we;
   logic [IDX_W-1:0]    meta_waddr;
   meta_type            meta_wdata;

   assign key_w = req_ff.client_key[KEY_BITS-1:0];
   assign hit   = meta_q_ff.valid && (meta_q_ff.key == key_w);

   always_comb begin
      if (req_ff.now_ticks >= meta_q_ff.last_seen) begin
         idle_ok = (req_ff.now_ticks - meta_q_ff.last_seen) >= timeout_ff;
      end else begin
         idle_ok = (timeout_ff == '0);
      end
   end
   assign this_idle = meta_q_ff.valid && idle_ok;

   assign allowed  = cnt_ff < lim_ff;
   assign cnt_next = allowed ? cnt_ff + CNT_W'(1) : cnt_ff;
   assign pos_sum  = (HEAD_W+1)'(head_ff) + (HEAD_W+1)'(cnt_ff);
   assign push_pos = (pos_sum >= (HEAD_W+1)'(MAX_ATTEMPTS))
                     ? HEAD_W'(pos_sum - (HEAD_W+1)'(MAX_ATTEMPTS))
                     : HEAD_W'(pos_sum);
   assign st_base    = ST_W'(slot_ff) * ST_W'(MAX_ATTEMPTS);
   assign st_rd_addr = st_base + ST_W'(head_ff);
   assign st_wr_addr = st_base + ST_W'(push_pos);

   assign meta_we    = cmd.meta_clr || (cmd.rec_eval && this_idle) || cmd.decide;
   assign meta_waddr = cmd.decide ? slot_ff : ptr_ff;
   always_comb begin
      meta_wdata = '0;
      if (cmd.decide) begin
         meta_wdata.valid     = 1'b1;
         meta_wdata.key       = key_w;
         meta_wdata.last_seen = req_ff.now_ticks;
         meta_wdata.head      = head_ff;
         meta_wdata.count     = cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_waddr] <= meta_wdata;
      end
      if (cmd.meta_rd) begin
         meta_q_ff <= meta_mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide && allowed) begin
         stamp_mem[st_wr_addr] <= req_ff.now_ticks;
      end
      if (cmd.stamp_rd) begin
         stamp_q_ff <= stamp_mem[st_rd_addr];
      end
   end

   always_comb begin
      req_in        = req_ff;
      cutoff_in     = cutoff_ff;
      win_ok_in     = win_ok_ff;
      lim_in        = lim_ff;
      timeout_in    = csr_we ? csr_wdata : timeout_ff;
      ptr_in        = ptr_ff;
      cand_found_in = cand_found_ff;
      cand_slot_in  = cand_slot_ff;
      slot_in       = slot_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      fresh_in      = fresh_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;

      if (cmd.load_req) begin
         req_in        = req_data;
         win_ok_in     = req_data.now_ticks >= TIME_W'(req_data.window_ticks);
         cutoff_in     = req_data.now_ticks - TIME_W'(req_data.window_ticks);
         lim_in        = ({1'b0, req_data.attempt_limit} > (LIMIT_W+1)'(MAX_ATTEMPTS))
                         ? CNT_W'(MAX_ATTEMPTS) : CNT_W'(req_data.attempt_limit);
         cand_found_in = 1'b0;
      end
      if (cmd.clr_ptr) begin
         ptr_in = '0;
      end else if (cmd.inc_ptr) begin
         ptr_in = ptr_ff + IDX_W'(1);
      end
      if (cmd.scan_eval) begin
         if (!meta_q_ff.valid && !cand_found_ff) begin
            cand_found_in = 1'b1;
            cand_slot_in  = ptr_ff;
         end
         if (hit) begin
            slot_in  = ptr_ff;
            head_in  = meta_q_ff.head;
            cnt_in   = meta_q_ff.count;
            fresh_in = 1'b0;
         end
      end
      if (cmd.rec_eval && this_idle && !cand_found_ff) begin
         cand_found_in = 1'b1;
         cand_slot_in  = ptr_ff;
      end
      if (cmd.alloc) begin
         slot_in  = cand_slot_ff;
         head_in  = '0;
         cnt_in   = '0;
         fresh_in = 1'b1;
      end
      if (cmd.pop) begin
         head_in = (head_ff == HEAD_W'(MAX_ATTEMPTS - 1)) ? '0 : head_ff + HEAD_W'(1);
         cnt_in  = cnt_ff - CNT_W'(1);
      end
      if (cmd.decide) begin
         cnt_in                    = cnt_next;
         res_in.allowed            = allowed;
         res_in.attempts_in_window = ATT_W'(cnt_next);
         res_in.new_entry          = fresh_ff;
         res_in.untracked          = 1'b0;
      end
      if (cmd.untrack) begin
         res_in.allowed            = 1'b1;
         res_in.attempts_in_window = '0;
         res_in.new_entry          = 1'b0;
         res_in.untracked          = 1'b1;
      end
      if (cmd.rsp_load) begin
         rsp_data_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         timeout_ff <= IDLE_TIMEOUT_RESET;
      end else begin
         ptr_ff     <= ptr_in;
         timeout_ff <= timeout_in;
      end
      req_ff        <= req_in;
      cutoff_ff     <= cutoff_in;
      win_ok_ff     <= win_ok_in;
      lim_ff        <= lim_in;
      cand_found_ff <= cand_found_in;
      cand_slot_ff  <= cand_slot_in;
      slot_ff       <= slot_in;
      head_ff       <= head_in;
      cnt_ff        <= cnt_in;
      fresh_ff      <= fresh_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign sts.last_ptr   = (ptr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign sts.hit        = hit;
   assign sts.cand_found = cand_found_ff;
   assign sts.cnt_zero   = (cnt_ff == '0);
   assign sts.win_ok     = win_ok_ff;
   assign sts.expire     = stamp_q_ff <= cutoff_ff;

   assign rsp_data = rsp_data_ff;

endmodule

// File: hdl/swrl_ctrl.sv
// Controller: sequences clearing, key search, reclaim, expiry and decision.
// Depends on swrl_pkg; commands swrl_datapath.
module swrl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  swrl_pkg::sts_type sts,
   output swrl_pkg::cmd_type cmd
);
   import swrl_pkg::*;

   typedef enum logic [11:0] {
      ST_CLEAR  = 12'b000000000001,
      ST_IDLE   = 12'b000000000010,
      ST_S_RD   = 12'b000000000100,
      ST_S_EV   = 12'b000000001000,
      ST_S_END  = 12'b000000010000,
      ST_R_RD   = 12'b000000100000,
      ST_R_EV   = 12'b000001000000,
      ST_R_END  = 12'b000010000000,
      ST_X_RD   = 12'b000100000000,
      ST_X_EV   = 12'b001000000000,
      ST_DECIDE = 12'b010000000000,
      ST_DONE   = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.meta_clr = 1'b1;
            if (sts.last_ptr) begin
               cmd.clr_ptr = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.inc_ptr = 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               cmd.clr_ptr  = 1'b1;
               state_in     = ST_S_RD;
            end
         end
         ST_S_RD: begin
            cmd.meta_rd = 1'b1;
            state_in    = ST_S_EV;
         end
         ST_S_EV: begin
            cmd.scan_eval = 1'b1;
            if (sts.hit) begin
               state_in = ST_X_RD;
            end else if (sts.last_ptr) begin
               state_in = ST_S_END;
            end else begin
               cmd.inc_ptr = 1'b1;
               state_in    = ST_S_RD;
            end
         end
         ST_S_END: begin
            if (sts.cand_found) begin
               cmd.alloc = 1'b1;
               state_in  = ST_DECIDE;
            end else begin
               cmd.clr_ptr = 1'b1;
               state_in    = ST_R_RD;
            end
         end
         ST_R_RD: begin
            cmd.meta_rd = 1'b1;
            state_in    = ST_R_EV;
         end
         ST_R_EV: begin
            cmd.rec_eval = 1'b1;
            if (sts.last_ptr) begin
               state_in = ST_R_END;
            end else begin
               cmd.inc_ptr = 1'b1;
               state_in    = ST_R_RD;
            end
         end
         ST_R_END: begin
            if (sts.cand_found) begin
               cmd.alloc = 1'b1;
               state_in  = ST_DECIDE;
            end else begin
               cmd.untrack = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_X_RD: begin
            if (sts.cnt_zero || !sts.win_ok) begin
               state_in = ST_DECIDE;
            end else begin
               cmd.stamp_rd = 1'b1;
               state_in     = ST_X_EV;
            end
         end
         ST_X_EV: begin
            if (sts.expire) begin
               cmd.pop  = 1'b1;
               state_in = ST_X_RD;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/sliding_window_rate_limiter.sv
// Top level of the per-client sliding-window rate limiter.
// Depends on swrl_pkg, swrl_ctrl and swrl_datapath.
//
// One request is handled at a time. After reset the block sweeps its 1024-entry
// table, one entry a cycle, with req_stall high. A request for a known key reads
// and checks the entries in order until it finds its key, then drops expired
// stamps one by one, decides and presents the result; a new key scans the whole
// table, and when the table is full a reclaim sweep of the whole table follows.
// The search reads each entry in one state and evaluates it in the next. The
// result sits in an output register, so a new request is taken while the
// previous result still waits.
module sliding_window_rate_limiter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  swrl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output swrl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [47:0]       csr_wdata
);
   import swrl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   swrl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   swrl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb_sliding_window_rate_limiter.sv
// Self-checking testbench for the sliding-window rate limiter.
// Depends on swrl_pkg and the sliding_window_rate_limiter RTL only.
// Keeps its own copy of the table to predict each transfer on the result side.
`timescale 1ns / 100ps

module tb_sliding_window_rate_limiter;
   import swrl_pkg::*;

   localparam int  CYCLE_LIMIT = 20000000;
   localparam int  LONG_HOLD   = 6000;
   localparam int  PEND_DEPTH  = 1024;
   localparam logic [47:0] TIME_MAX = 48'hFFFF_FFFF_FFFF;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_we = 1'b0;
   logic [47:0] csr_wdata = '0;

   sliding_window_rate_limiter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow table
   logic [47:0] timeout_shadow;
   bit          tbl_valid [TABLE_ENTRIES];
   logic [31:0] tbl_key   [TABLE_ENTRIES];
   logic [47:0] tbl_seen  [TABLE_ENTRIES];
   int          tbl_head  [TABLE_ENTRIES];
   int          tbl_count [TABLE_ENTRIES];
   logic [47:0] tbl_stamp [TABLE_ENTRIES][MAX_ATTEMPTS];

   req_type pend_mem [PEND_DEPTH];
   int      pend_wr = 0;
   int      pend_rd = 0;
   rsp_type verdict_mem [PEND_DEPTH];
   int      verdict_wr = 0;
   int      verdict_rd = 0;
   bit      failed = 0;
   bit      no_idle = 0;
   bit      long_hold = 0;
   int      cycles = 0;

   function automatic int pick_gap();
      if (no_idle || $urandom_range(0, 9) < 6) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic void add_req(req_type r);
      pend_mem[pend_wr] = r;
      pend_wr++;
   endfunction

   function automatic rsp_type admit(req_type r);
      rsp_type     v;
      int          e;
      int          lim;
      bit          fresh;
      logic [47:0] now;
      logic [47:0] idle;
      logic [63:0] cutoff;
      e = -1;
      fresh = 0;
      now = r.now_ticks;
      lim = (r.attempt_limit > MAX_ATTEMPTS) ? MAX_ATTEMPTS : r.attempt_limit;
      for (int i = 0; i < TABLE_ENTRIES && e < 0; i++)
         if (tbl_valid[i] && tbl_key[i] == r.client_key) e = i;
      if (e < 0) begin
         for (int i = 0; i < TABLE_ENTRIES && e < 0; i++)
            if (!tbl_valid[i]) e = i;
         if (e < 0) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               idle = (now >= tbl_seen[i]) ? now - tbl_seen[i] : '0;
               if (tbl_valid[i] && idle >= timeout_shadow) begin
                  tbl_valid[i] = 0;
                  if (e < 0) e = i;
               end
            end
         end
         if (e >= 0) begin
            tbl_valid[e] = 1;
            tbl_key[e] = r.client_key;
            tbl_head[e] = 0;
            tbl_count[e] = 0;
            fresh = 1;
         end
      end
      if (e < 0) begin
         v.allowed = 1'b1;
         v.attempts_in_window = '0;
         v.new_entry = 1'b0;
         v.untracked = 1'b1;
         return v;
      end
      tbl_seen[e] = now;
      if (64'(now) >= 64'(r.window_ticks)) begin
         cutoff = 64'(now) - 64'(r.window_ticks);
         while (tbl_count[e] > 0 && 64'(tbl_stamp[e][tbl_head[e]]) <= cutoff) begin
            tbl_head[e] = (tbl_head[e] + 1) % MAX_ATTEMPTS;
            tbl_count[e]--;
         end
      end
      v.allowed = tbl_count[e] < lim;
      if (v.allowed) begin
         tbl_stamp[e][(tbl_head[e] + tbl_count[e]) % MAX_ATTEMPTS] = now;
         tbl_count[e]++;
      end
      v.attempts_in_window = ATT_W'(tbl_count[e]);
      v.new_entry = fresh;
      v.untracked = 1'b0;
      return v;
   endfunction

   // request driver
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            verdict_mem[verdict_wr] = admit(req_data);
            verdict_wr++;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pend_rd != pend_wr) begin
               req_data <= pend_mem[pend_rd];
               pend_rd++;
               req_valid <= 1'b1;
               req_gap = pick_gap();
               if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   int stall_left = 0;
   rsp_type want;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_rd == verdict_wr) begin
               $error("unexpected result transfer %h", rsp_data);
               failed = 1;
            end else begin
               want = verdict_mem[verdict_rd];
               verdict_rd++;
               if (rsp_data.allowed !== want.allowed) begin
                  $error("allowed: expected %0d actual %0d", want.allowed, rsp_data.allowed);
                  failed = 1;
               end
               if (rsp_data.attempts_in_window !== want.attempts_in_window) begin
                  $error("attempts_in_window: expected %0d actual %0d",
                         want.attempts_in_window, rsp_data.attempts_in_window);
                  failed = 1;
               end
               if (rsp_data.new_entry !== want.new_entry) begin
                  $error("new_entry: expected %0d actual %0d",
                         want.new_entry, rsp_data.new_entry);
                  failed = 1;
               end
               if (rsp_data.untracked !== want.untracked) begin
                  $error("untracked: expected %0d actual %0d",
                         want.untracked, rsp_data.untracked);
                  failed = 1;
               end
            end
         end
         if (long_hold) begin
            long_hold = 0;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            stall_left = pick_gap();
            rsp_stall <= (stall_left > 0);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[sliding_window_rate_limiter] ERROR");
         $finish;
      end
   end

   function automatic req_type mk(logic [31:0] k, logic [47:0] t, logic [5:0] l,
                                  logic [31:0] w);
      req_type r;
      r.client_key = k;
      r.now_ticks = t;
      r.attempt_limit = l;
      r.window_ticks = w;
      return r;
   endfunction

   task automatic drain();
      while (pend_rd != pend_wr || verdict_rd != pend_rd) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_timeout(logic [47:0] v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      timeout_shadow = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   logic [31:0] pool [12];
   logic [47:0] tnow;

   initial begin
      timeout_shadow = IDLE_TIMEOUT_RESET;
      foreach (tbl_valid[i]) tbl_valid[i] = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: limits, extremes, backwards time, long window
      add_req(mk(32'h0, 48'd100, 6'd0, 32'd10));
      add_req(mk(32'h0, 48'd101, 6'd1, 32'd10));
      add_req(mk(32'h0, 48'd102, 6'd1, 32'd10));
      add_req(mk(32'h0, 48'd111, 6'd1, 32'd10));
      add_req(mk(32'h0, 48'd50, 6'd5, 32'd10));
      add_req(mk(32'h0, 48'd5, 6'd5, 32'hFFFF_FFFF));
      add_req(mk(32'hFFFF_FFFF, 48'd0, 6'd63, 32'd1));
      for (int i = 0; i < 34; i++)
         add_req(mk(32'hFFFF_FFFF, 48'd1 + i, (i < 17) ? 6'd63 : 6'd33,
                    32'hFFFF_FFFF));
      add_req(mk(32'hFFFF_FFFF, TIME_MAX, 6'd32, 32'hFFFF_FFFF));
      add_req(mk(32'hFFFF_FFFF, TIME_MAX, 6'd32, 32'd1));
      add_req(mk(32'h5555_AAAA, TIME_MAX, 6'd0, 32'd1));
      drain();

      // random traffic over a small key pool
      set_timeout(48'd5000);
      foreach (pool[i]) pool[i] = $urandom;
      tnow = 48'd1000;
      for (int n = 0; n < 320; n++) begin
         if ($urandom_range(0, 39) == 0) tnow = 48'({$urandom, $urandom});
         else tnow = tnow + $urandom_range(0, 40);
         add_req(mk(pool[$urandom_range(0, 11)], tnow, 6'($urandom_range(0, 63)),
                    ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 300)));
         if (n == 150) long_hold = 1;
      end
      drain();

      set_timeout(48'd1);
      for (int n = 0; n < 30; n++)
         add_req(mk(pool[$urandom_range(0, 3)], 48'd20 + n, 6'($urandom_range(0, 63)),
                    $urandom_range(1, 8)));
      drain();
      repeat (50) @(posedge clock);

      if (failed) $display("[sliding_window_rate_limiter] ERROR");
      else $display("[sliding_window_rate_limiter] OK");
      $finish;
   end

endmodule

// File: filelist.f
hdl/swrl_pkg.sv
hdl/swrl_datapath.sv
hdl/swrl_ctrl.sv
hdl/sliding_window_rate_limiter.sv
tb/tb_sliding_window_rate_limiter.sv
